// ===== hw/rtl/swml_pkg.sv =====
// Shared types and constants of the sliding window peak-level detector.
// Depends on nothing; imported by the top level, the front end and the back end.
`default_nettype none

package swml_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W = 17;
	localparam int WL_CFG_W = 11;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [LEVEL_W-1:0] level_t;

	// One classified request on its way from the front end to the level queue.
	typedef struct packed {
		logic valid;
		level_t level;
	} level_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sliding_window_max_level.sv =====
// Top level of the sliding window peak-level detector: configuration
// registers and the connection of front end, level queue and back end.
// Depends on swml_pkg, swml_front, swml_fifo and swml_back.
//
// Usage. Sample pairs enter through a queue-style port: a request is taken
// at a clock edge where push is high and full is low. Each request yields
// exactly one peak_level, shown while empty is low and taken when pop is
// high at an edge. The level is sample_left in mono mode and
// (|left| + |right|) / 2 in stereo mode; peak_level is the maximum of the
// last window_length levels, the current one included.
// A result passes through the front-end register, the level queue and the
// doubling chain of delay lines before it becomes visible in the result queue:
// one stage for each power of two up to MAX_WINDOW. Throughput is one
// request per cycle in steady state. If the receiver stops popping, the
// result queue fills, the back end stops issuing on credits, the level
// queue fills and full rises; nothing is lost.
// Reset sets window_length to 1024 (or MAX_WINDOW if smaller), stereo mode
// off, and empties the window; a write of window_length empties it again,
// so early results include the zeros of the empty slots. No clearing pass
// is needed: a fill count masks slots older than the last clear.
// Registers sit at byte 0 (window_length) and byte 4 (stereo_mode); write
// them only while no request is in flight.
`default_nettype none

module sliding_window_max_level #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              push,
	output logic              full,
	input  swml_pkg::sample_t sample_left,
	input  swml_pkg::sample_t sample_right,
	output logic              empty,
	input  logic              pop,
	output swml_pkg::level_t  peak_level
);
	import swml_pkg::*;

	localparam int WL_W = $clog2(MAX_WINDOW + 1);
	localparam int RESET_WL = (MAX_WINDOW < 1024) ? MAX_WINDOW : 1024;

	typedef enum logic {
		REG_WINDOW_LENGTH,
		REG_STEREO_MODE
	} reg_idx_t;

	logic [WL_W-1:0] window_length_q;
	logic stereo_mode_q;
	logic cfg_write;
	logic wl_clear;
	reg_idx_t reg_idx;
	logic [WL_CFG_W-1:0] wl_raw;
	logic [WL_W-1:0] wl_clamped;

	level_req_t req_s1;
	logic lq_full;
	logic lq_empty;
	logic lq_pop;
	logic [LEVEL_W-1:0] lq_rdata;

	// The register port never waits; a write lands in the access phase.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wl_clear = cfg_write && (reg_idx == REG_WINDOW_LENGTH);

	// Only the low WL_CFG_W bits of the written word count. A length of zero
	// acts as one, and lengths past the window store saturate at its size.
	always_comb begin
		wl_raw = pwdata[WL_CFG_W-1:0];
		if (wl_raw == '0) begin
			wl_clamped = WL_W'(1);
		end else if (32'(wl_raw) > 32'(MAX_WINDOW)) begin
			wl_clamped = WL_W'(MAX_WINDOW);
		end else begin
			wl_clamped = WL_W'(wl_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WL_W'(RESET_WL);
			stereo_mode_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_WINDOW_LENGTH: window_length_q <= wl_clamped;
				REG_STEREO_MODE: stereo_mode_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_LENGTH: prdata = 32'(window_length_q);
			REG_STEREO_MODE: prdata = {31'b0, stereo_mode_q};
		endcase
	end

	// Front end: classifies each sample pair into a level.
	swml_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample_left(sample_left),
		.sample_right(sample_right),
		.stereo_mode(stereo_mode_q),
		.req_s1(req_s1),
		.req_full(lq_full)
	);

	// Level queue: lets the front end keep accepting while the back end
	// waits for result credits, and the other way around.
	swml_fifo #(
		.WIDTH(LEVEL_W),
		.DEPTH(4)
	) u_lq (
		.clk(clk),
		.arst_n(arst_n),
		.push(req_s1.valid),
		.wdata(req_s1.level),
		.full(lq_full),
		.pop(lq_pop),
		.rdata(lq_rdata),
		.empty(lq_empty)
	);

	// Back end: sliding maximum and the result queue.
	swml_back #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.window_length(window_length_q),
		.clear(wl_clear),
		.lq_empty(lq_empty),
		.lq_level(level_t'(lq_rdata)),
		.lq_pop(lq_pop),
		.empty(empty),
		.pop(pop),
		.peak_level(peak_level)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/swml_fifo.sv =====
// Small synchronous queue with full and empty flags.
// Depends on nothing; used for the level queue and the result queue.
`default_nettype none

module swml_fifo #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/swml_delay.sv =====
// Ring-buffer delay line: returns the value written a given number of writes ago.
// Depends on nothing; DEPTH must be a power of two of at least two.
`default_nettype none

module swml_delay #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 17,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] lag,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;
	logic [ADDR_W-1:0] wptr_q;
	logic [ADDR_W-1:0] raddr;

	// A lag of zero reads the slot about to be overwritten, which is the
	// value written DEPTH writes ago; any other lag reads that many writes back.
	assign raddr = wptr_q - lag;
	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q <= mem_q[raddr];
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
		end else if (advance) begin
			wptr_q <= wptr_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/swml_front.sv =====
// Front end: accepts sample pairs and turns each into one level value.
// Depends on swml_pkg; feeds the level queue.
`default_nettype none

module swml_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  swml_pkg::sample_t     sample_left,
	input  swml_pkg::sample_t     sample_right,
	input  logic                  stereo_mode,
	output swml_pkg::level_req_t  req_s1,
	input  logic                  req_full
);
	import swml_pkg::*;

	logic valid_s1;
	level_t level_s1;
	logic advance;
	logic [LEVEL_W-1:0] ext_l;
	logic [LEVEL_W-1:0] ext_r;
	logic [LEVEL_W-1:0] abs_l;
	logic [LEVEL_W-1:0] abs_r;
	logic [LEVEL_W:0] sum;
	level_t level;

	assign advance = !valid_s1 || !req_full;
	assign full = !advance;

	always_comb begin
		ext_l = {sample_left[SAMPLE_W-1], sample_left};
		ext_r = {sample_right[SAMPLE_W-1], sample_right};
		abs_l = ext_l[LEVEL_W-1] ? (~ext_l + 1'b1) : ext_l;
		abs_r = ext_r[LEVEL_W-1] ? (~ext_r + 1'b1) : ext_r;
		sum = {1'b0, abs_l} + {1'b0, abs_r};
		// The halved sum of two magnitudes never exceeds 32768, so it stays
		// positive in the signed level format.
		level = stereo_mode ? level_t'(sum[LEVEL_W:1]) : level_t'(ext_l);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			level_s1 <= level;
		end
	end

	assign req_s1.valid = valid_s1;
	assign req_s1.level = level_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/swml_back.sv =====
// Back end: doubling pipeline of delay lines that forms the sliding maximum,
// plus the result queue and its credit counter. Depends on swml_pkg,
// swml_delay and swml_fifo.
`default_nettype none

module swml_back #(
	parameter int MAX_WINDOW = 1024,
	localparam int WL_W = $clog2(MAX_WINDOW + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WL_W-1:0]   window_length,
	input  logic              clear,
	input  logic              lq_empty,
	input  swml_pkg::level_t  lq_level,
	output logic              lq_pop,
	output logic              empty,
	input  logic              pop,
	output swml_pkg::level_t  peak_level
);
	import swml_pkg::*;

	localparam int KMAX = $clog2(MAX_WINDOW + 1) - 1;
	localparam int CNT_W = WL_W;
	localparam int FD = 2 ** KMAX;
	localparam int PIPE_LAT = KMAX + 3;
	localparam int OUT_DEPTH = 2 ** $clog2(PIPE_LAT + 2);
	localparam int CRED_W = $clog2(OUT_DEPTH + 1);

	logic issue;
	logic [CRED_W-1:0] credit_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_full;
	logic out_pop;
	logic [LEVEL_W-1:0] out_rdata;

	logic valid_sj [0:KMAX];
	logic [CNT_W-1:0] idx_sj [0:KMAX];
	level_t amax_sj [0:KMAX];
	level_t m_c [0:KMAX];
	logic [LEVEL_W-1:0] dly_raw [1:KMAX];
	level_t last_level_q;
	level_t dly_s1;

	logic valid_sf;
	logic [CNT_W-1:0] idx_sf;
	level_t amax_sf;
	logic [LEVEL_W-1:0] dly_sf;
	level_t result;

	logic [KMAX:1] en;
	logic [KMAX-1:0] lag_d;
	logic [WL_W-1:0] top_bit;
	logic [WL_W-1:0] rest;

	// Level j is in use while 2**j fits in the window; the remainder of the
	// window past its largest power of two sets the lag of the final line.
	always_comb begin
		top_bit = '0;
		for (int j = 1; j <= KMAX; j++) begin
			en[j] = (window_length >= WL_W'(2 ** j));
		end
		for (int b = 0; b < WL_W; b++) begin
			if (window_length[b]) begin
				top_bit = WL_W'(1) << b;
			end
		end
		rest = window_length & ~top_bit;
		lag_d = rest[KMAX-1:0];
	end

	assign issue = !lq_empty && (credit_q != '0);
	assign lq_pop = issue;
	assign out_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRED_W'(OUT_DEPTH);
			cnt_q <= '0;
		end else begin
			if (issue && !out_pop) begin
				credit_q <= credit_q - 1'b1;
			end else if (out_pop && !issue) begin
				credit_q <= credit_q + 1'b1;
			end
			if (clear) begin
				cnt_q <= '0;
			end else if (issue && (cnt_q != CNT_W'(MAX_WINDOW))) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= KMAX; j++) begin
				valid_sj[j] <= 1'b0;
			end
			valid_sf <= 1'b0;
		end else begin
			valid_sj[0] <= issue;
			for (int j = 1; j <= KMAX; j++) begin
				valid_sj[j] <= valid_sj[j-1];
			end
			valid_sf <= valid_sj[KMAX];
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_sj[0] <= cnt_q;
			amax_sj[0] <= lq_level;
		end
		for (int j = 1; j <= KMAX; j++) begin
			if (valid_sj[j-1]) begin
				idx_sj[j] <= idx_sj[j-1];
				amax_sj[j] <= m_c[j-1];
			end
		end
		if (valid_sj[0]) begin
			last_level_q <= m_c[0];
			dly_s1 <= last_level_q;
		end
		if (valid_sj[KMAX]) begin
			idx_sf <= idx_sj[KMAX];
			amax_sf <= m_c[KMAX];
		end
	end

	assign dly_raw[1] = dly_s1;

	for (genvar j = 2; j <= KMAX; j++) begin : g_lvl
		swml_delay #(
			.DEPTH(2 ** (j - 1)),
			.WIDTH(LEVEL_W)
		) u_dly (
			.clk(clk),
			.arst_n(arst_n),
			.advance(valid_sj[j-1]),
			.wdata(m_c[j-1]),
			.lag('0),
			.rdata(dly_raw[j])
		);
	end

	// Level j doubles the span: max of this item's value and the one from
	// 2**(j-1) items back. Slots from before the last clear count as zero.
	always_comb begin
		level_t older;
		m_c[0] = amax_sj[0];
		for (int j = 1; j <= KMAX; j++) begin
			older = (idx_sj[j] >= CNT_W'(2 ** (j - 1))) ? level_t'(dly_raw[j]) : '0;
			m_c[j] = (en[j] && (older > amax_sj[j])) ? older : amax_sj[j];
		end
	end

	swml_delay #(
		.DEPTH(FD),
		.WIDTH(LEVEL_W)
	) u_tail (
		.clk(clk),
		.arst_n(arst_n),
		.advance(valid_sj[KMAX]),
		.wdata(m_c[KMAX]),
		.lag(lag_d),
		.rdata(dly_sf)
	);

	always_comb begin
		level_t older;
		older = (idx_sf >= CNT_W'(lag_d)) ? level_t'(dly_sf) : '0;
		result = ((lag_d != '0) && (older > amax_sf)) ? older : amax_sf;
	end

	swml_fifo #(
		.WIDTH(LEVEL_W),
		.DEPTH(OUT_DEPTH)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_sf),
		.wdata(result),
		.full(out_full),
		.pop(pop),
		.rdata(out_rdata),
		.empty(empty)
	);

	assign peak_level = level_t'(out_rdata);

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CRED_W'(OUT_DEPTH))
		else $error("credit counter above result queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_sf && out_full))
		else $error("result arrived at a full result queue");

	a_issue_enters: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> valid_sj[0])
		else $error("issued request missing from first stage");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (cnt_q == '0))
		else $error("fill count not cleared by window write");

endmodule

`default_nettype wire
